// ===== hw/rtl/vpo_pkg.sv =====
`timescale 1ns / 1ps

package vpo_pkg;

	// Channels per chip, default voice count and catch-up limit
	localparam int PER_CHIP          = 3;
	localparam int DEF_VOICE_COUNT   = 6;
	localparam int DEF_MAX_CATCHUP   = 10;

	// Register indexes
	localparam logic REG_DUTY_A = 1'b0;
	localparam logic REG_DUTY_B = 1'b1;

	// Input item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;
	localparam logic [1:0] KIND_SET   = 2'd3;

	// Waveform codes
	localparam logic [1:0] WAVE_SQUARE = 2'd0;
	localparam logic [1:0] WAVE_SAW    = 2'd1;
	localparam logic [1:0] WAVE_TRI    = 2'd2;
	localparam logic [1:0] WAVE_DPULSE = 2'd3;

	localparam logic [3:0]  DUTY_RESET = 4'd8;
	localparam logic [18:0] STEP_NUM   = 19'd327680;
	localparam logic [16:0] STEP_MAX   = 17'd65536;
	localparam logic [15:0] PHASE_START = 16'hFFFF;
	localparam int          DIV_BITS   = 19;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  steps;
		logic [2:0]  voice;
		logic [15:0] period;
		logic [3:0]  volume;
		logic [1:0]  waveform;
		logic [3:0]  pwm_depth;
		logic [15:0] pwm_rate;
	} in_beat_t;

	typedef struct packed {
		logic       chip;
		logic [1:0] channel;
		logic [3:0] level;
		logic       last;
	} out_beat_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_START,
		OP_STOP,
		OP_SET
	} op_t;

	// Classified command held in the queue
	typedef struct packed {
		op_t         op;
		logic [2:0]  voice;
		logic        chip;
		logic [1:0]  chan;
		logic [3:0]  steps;
		logic [15:0] period;
		logic [3:0]  volume;
		logic [1:0]  waveform;
		logic [3:0]  pwm_depth;
		logic [15:0] pwm_rate;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ADV,
		ST_LVL,
		ST_EMIT,
		ST_ONE
	} st_t;

endpackage

// ===== hw/rtl/vpo_div.sv =====
`timescale 1ns / 1ps

module vpo_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [18:0] quot
);

	logic [16:0] rem_q;
	logic [18:0] quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] rem_sh;
	logic        ge;

	// One quotient bit a cycle, dividend bits taken MSB first
	assign rem_sh = {rem_q[15:0], vpo_pkg::STEP_NUM[cnt_q]};
	assign ge     = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(vpo_pkg::DIV_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
			quot_q <= {quot_q[17:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== hw/rtl/vpo_front.sv =====
`timescale 1ns / 1ps

module vpo_front #(
	parameter int VOICE_COUNT = vpo_pkg::DEF_VOICE_COUNT,
	parameter int MAX_CATCHUP = vpo_pkg::DEF_MAX_CATCHUP
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vpo_pkg::in_beat_t in_data,
	output logic              cmd_valid,
	output vpo_pkg::cmd_t     cmd,
	input  logic              pop
);

	localparam int LIVE = (VOICE_COUNT < 2 * vpo_pkg::PER_CHIP) ?
		VOICE_COUNT : 2 * vpo_pkg::PER_CHIP;

	vpo_pkg::cmd_t q_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	vpo_pkg::cmd_t cls;
	logic          keep;
	logic          push;

	// Classify the beat: map kind to op, clamp steps, split voice into chip and channel
	always_comb begin
		cls           = '0;
		cls.voice     = in_data.voice;
		cls.period    = in_data.period;
		cls.volume    = in_data.volume;
		cls.waveform  = in_data.waveform;
		cls.pwm_depth = in_data.pwm_depth;
		cls.pwm_rate  = in_data.pwm_rate;
		case (in_data.kind)
			vpo_pkg::KIND_TICK:  cls.op = vpo_pkg::OP_TICK;
			vpo_pkg::KIND_START: cls.op = vpo_pkg::OP_START;
			vpo_pkg::KIND_STOP:  cls.op = vpo_pkg::OP_STOP;
			default:             cls.op = vpo_pkg::OP_SET;
		endcase
		if (in_data.steps == 4'd0)
			cls.steps = 4'd1;
		else if (in_data.steps > 4'(MAX_CATCHUP))
			cls.steps = 4'(MAX_CATCHUP);
		else
			cls.steps = in_data.steps;
		if (in_data.voice >= 3'(vpo_pkg::PER_CHIP)) begin
			cls.chip = 1'b1;
			cls.chan = 2'(in_data.voice - 3'(vpo_pkg::PER_CHIP));
		end else begin
			cls.chip = 1'b0;
			cls.chan = in_data.voice[1:0];
		end
	end

	// Voice commands beyond the bank are dropped here
	assign keep     = (in_data.kind == vpo_pkg::KIND_TICK) || (in_data.voice < 3'(LIVE));
	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready && keep;

	// Two-entry queue to the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_q[wp_q] <= cls;
	end

	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_q[rp_q];

endmodule

// ===== hw/rtl/vpo_back.sv =====
`timescale 1ns / 1ps

module vpo_back #(
	parameter int VOICE_COUNT = vpo_pkg::DEF_VOICE_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  vpo_pkg::cmd_t      cmd,
	output logic               pop,
	input  logic [3:0]         duty_a,
	input  logic [3:0]         duty_b,
	output logic               out_valid,
	input  logic               out_ready,
	output vpo_pkg::out_beat_t out_data
);

	localparam int LIVE = (VOICE_COUNT < 2 * vpo_pkg::PER_CHIP) ?
		VOICE_COUNT : 2 * vpo_pkg::PER_CHIP;
	localparam int VW = (LIVE > 1) ? $clog2(LIVE) : 1;

	// Per-voice state
	logic [15:0] phase_q   [LIVE];
	logic [16:0] step_q    [LIVE];
	logic        on_q      [LIVE];
	logic [3:0]  peak_q    [LIVE];
	logic [3:0]  duty_q    [LIVE];
	logic [1:0]  wave_q    [LIVE];
	logic [3:0]  wr_q      [LIVE];
	logic [15:0] lfo_ph_q  [LIVE];
	logic [15:0] lfo_st_q  [LIVE];
	logic [3:0]  depth_q   [LIVE];

	vpo_pkg::st_t       st_q, st_d;
	logic               turn_q;
	logic [1:0]         c_q;
	logic [3:0]         lvl_q [3];
	logic [2:0]         chg_q;
	logic               out_valid_q;
	vpo_pkg::out_beat_t out_q;

	logic               out_free;
	logic [2:0]         v_tick;
	logic [2:0]         v_sel;
	logic [VW-1:0]      vi;
	logic               act;
	logic               div_go;
	logic               div_done;
	logic [18:0]        div_q;
	logic               do_adv, do_lvl, do_start, do_stop, do_set, do_emit, c_inc;
	logic               last_tick;
	logic               emit_move;
	vpo_pkg::out_beat_t emit_d;
	logic [16:0]        start_step;

	logic [20:0] adv_prod;
	logic [19:0] lfo_prod;
	logic [14:0] lfo_fold;
	logic [18:0] m_prod;
	logic [4:0]  duty_sum;
	logic [3:0]  duty_eff;
	logic [15:0] p;
	logic [19:0] saw_prod;
	logic [14:0] tri_fold;
	logic [18:0] tri_prod;
	logic [3:0]  lvl;

	vpo_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.divisor (cmd.period),
		.done    (div_done),
		.quot    (div_q)
	);

	assign out_free = !out_valid_q || out_ready;

	// Voice selection
	assign v_tick = turn_q ? (3'(vpo_pkg::PER_CHIP) + {1'b0, c_q}) : {1'b0, c_q};
	assign v_sel  = (st_q == vpo_pkg::ST_ADV || st_q == vpo_pkg::ST_LVL) ? v_tick : cmd.voice;
	assign vi     = v_sel[VW-1:0];
	assign act    = (v_tick < 3'(LIVE)) && on_q[vi] && (step_q[vi] != 17'd0);

	// Phase advance
	assign adv_prod = {4'b0, step_q[vi]} * {17'b0, cmd.steps};
	assign lfo_prod = {4'b0, lfo_st_q[vi]} * {16'b0, cmd.steps};

	// Duty sweep from the triangle LFO
	assign lfo_fold = lfo_ph_q[vi][15] ? ~lfo_ph_q[vi][14:0] : lfo_ph_q[vi][14:0];
	assign m_prod   = {15'b0, depth_q[vi]} * {4'b0, lfo_fold};
	assign duty_sum = {1'b0, duty_q[vi]} + {1'b0, m_prod[18:15]};
	always_comb begin
		if (lfo_st_q[vi] == 16'd0)
			duty_eff = duty_q[vi];
		else if (duty_sum[4])
			duty_eff = 4'd15;
		else
			duty_eff = duty_sum[3:0];
	end

	// Waveform level
	assign p        = phase_q[vi];
	assign saw_prod = {16'b0, peak_q[vi]} * {4'b0, ~p};
	assign tri_fold = p[15] ? ~p[14:0] : p[14:0];
	assign tri_prod = {15'b0, peak_q[vi]} * {4'b0, tri_fold};
	always_comb begin
		case (wave_q[vi])
			vpo_pkg::WAVE_SAW: lvl = saw_prod[19:16];
			vpo_pkg::WAVE_TRI: lvl = tri_prod[18:15];
			vpo_pkg::WAVE_DPULSE:
				lvl = ((p[15:12] == 4'd0) || ({1'b0, p[15:12]} == {1'b0, duty_eff} + 5'd1)) ?
					peak_q[vi] : 4'd0;
			default: lvl = (p[15:12] < duty_eff) ? peak_q[vi] : 4'd0;
		endcase
	end

	// Start step: quotient clamped to 1..65536, zero period gives a silent voice
	always_comb begin
		if (cmd.period == 16'd0)
			start_step = 17'd0;
		else if (div_q > {2'b0, vpo_pkg::STEP_MAX})
			start_step = vpo_pkg::STEP_MAX;
		else if (div_q == 19'd0)
			start_step = 17'd1;
		else
			start_step = div_q[16:0];
	end

	always_comb begin
		case (c_q)
			2'd0:    last_tick = !chg_q[1] && !chg_q[2];
			2'd1:    last_tick = !chg_q[2];
			default: last_tick = 1'b1;
		endcase
	end

	assign emit_move = !chg_q[c_q] || out_free;

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			vpo_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						vpo_pkg::OP_TICK:  st_d = vpo_pkg::ST_ADV;
						vpo_pkg::OP_START: st_d = vpo_pkg::ST_DIV;
						vpo_pkg::OP_STOP:  st_d = vpo_pkg::ST_ONE;
						default:           st_d = vpo_pkg::ST_IDLE;
					endcase
				end
			end
			vpo_pkg::ST_DIV: begin
				if (div_done)
					st_d = vpo_pkg::ST_ONE;
			end
			vpo_pkg::ST_ADV: begin
				if (act)
					st_d = vpo_pkg::ST_LVL;
				else if (c_q == 2'd2)
					st_d = vpo_pkg::ST_EMIT;
			end
			vpo_pkg::ST_LVL: begin
				st_d = (c_q == 2'd2) ? vpo_pkg::ST_EMIT : vpo_pkg::ST_ADV;
			end
			vpo_pkg::ST_EMIT: begin
				if (emit_move && c_q == 2'd2)
					st_d = vpo_pkg::ST_IDLE;
			end
			vpo_pkg::ST_ONE: begin
				if (out_free)
					st_d = vpo_pkg::ST_IDLE;
			end
			default: st_d = vpo_pkg::ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop      = 1'b0;
		div_go   = 1'b0;
		do_adv   = 1'b0;
		do_lvl   = 1'b0;
		do_start = 1'b0;
		do_stop  = 1'b0;
		do_set   = 1'b0;
		do_emit  = 1'b0;
		c_inc    = 1'b0;
		emit_d   = '0;
		case (st_q)
			vpo_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						vpo_pkg::OP_START: div_go = 1'b1;
						vpo_pkg::OP_STOP:  do_stop = 1'b1;
						vpo_pkg::OP_SET: begin
							do_set = 1'b1;
							pop    = 1'b1;
						end
						default: ;
					endcase
				end
			end
			vpo_pkg::ST_DIV: do_start = div_done;
			vpo_pkg::ST_ADV: begin
				do_adv = act;
				c_inc  = !act;
			end
			vpo_pkg::ST_LVL: begin
				do_lvl = 1'b1;
				c_inc  = 1'b1;
			end
			vpo_pkg::ST_EMIT: begin
				emit_d.chip    = turn_q;
				emit_d.channel = c_q;
				emit_d.level   = lvl_q[c_q];
				emit_d.last    = last_tick;
				do_emit        = chg_q[c_q] && out_free;
				c_inc          = emit_move;
				pop            = emit_move && c_q == 2'd2;
			end
			vpo_pkg::ST_ONE: begin
				emit_d.chip    = cmd.chip;
				emit_d.channel = cmd.chan;
				emit_d.level   = 4'd0;
				emit_d.last    = 1'b1;
				do_emit        = out_free;
				pop            = out_free;
			end
			default: ;
		endcase
	end

	// Sequencer control registers and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= vpo_pkg::ST_IDLE;
			turn_q      <= 1'b0;
			c_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == vpo_pkg::ST_IDLE)
				c_q <= '0;
			else if (c_inc)
				c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
			if (st_q == vpo_pkg::ST_EMIT && emit_move && c_q == 2'd2)
				turn_q <= ~turn_q;
			if (do_emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Output beat and per-tick scratch
	always_ff @(posedge clk) begin
		if (do_emit)
			out_q <= emit_d;
		if (do_lvl)
			lvl_q[c_q] <= lvl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chg_q <= '0;
		end else if (st_q == vpo_pkg::ST_ADV && !act) begin
			chg_q[c_q] <= 1'b0;
		end else if (do_lvl) begin
			chg_q[c_q] <= lvl != wr_q[vi];
		end
	end

	// Voice state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIVE; i++) begin
				phase_q[i]  <= '0;
				step_q[i]   <= '0;
				on_q[i]     <= 1'b0;
				peak_q[i]   <= '0;
				duty_q[i]   <= vpo_pkg::DUTY_RESET;
				wave_q[i]   <= '0;
				wr_q[i]     <= '0;
				lfo_ph_q[i] <= '0;
				lfo_st_q[i] <= '0;
				depth_q[i]  <= '0;
			end
		end else begin
			if (do_adv) begin
				phase_q[vi] <= phase_q[vi] + adv_prod[15:0];
				if (lfo_st_q[vi] != 16'd0)
					lfo_ph_q[vi] <= lfo_ph_q[vi] + lfo_prod[15:0];
			end
			if (do_lvl)
				wr_q[vi] <= lvl;
			if (do_start) begin
				peak_q[vi]  <= '0;
				phase_q[vi] <= vpo_pkg::PHASE_START;
				on_q[vi]    <= 1'b1;
				duty_q[vi]  <= cmd.chip ? duty_b : duty_a;
				step_q[vi]  <= start_step;
				wr_q[vi]    <= '0;
			end
			if (do_stop) begin
				on_q[vi]    <= 1'b0;
				peak_q[vi]  <= '0;
				phase_q[vi] <= '0;
				step_q[vi]  <= '0;
				wr_q[vi]    <= '0;
			end
			if (do_set) begin
				peak_q[vi]   <= cmd.volume;
				wave_q[vi]   <= cmd.waveform;
				depth_q[vi]  <= cmd.pwm_depth;
				lfo_st_q[vi] <= cmd.pwm_rate;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/volume_pwm_oscillator_bank.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_ready       vpo_pkg::in_beat_t
// out       output     out_valid / out_ready     vpo_pkg::out_beat_t
// cfg       input      cfg_we (no wait)          cfg_index, cfg_data[3:0]
//
// A tick passes from the dispatch state through an advance step for each
// voice of the current chip and a level step for each running voice, then
// an emit step per channel, with waits on out_ready.
// A start runs the 19-step restoring divider for the phase step and then
// writes a zero beat; a stop writes one directly; a set ends at dispatch.
// Reset clears all voice state at once; duty registers come up at 8.
// A two-beat queue lets the input side run ahead while results stall.

module volume_pwm_oscillator_bank #(
	parameter int VOICE_COUNT = vpo_pkg::DEF_VOICE_COUNT,
	parameter int MAX_CATCHUP = vpo_pkg::DEF_MAX_CATCHUP
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vpo_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output vpo_pkg::out_beat_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data
);

	logic [3:0]    duty_a_q;
	logic [3:0]    duty_b_q;
	logic          cmd_valid;
	vpo_pkg::cmd_t cmd;
	logic          pop;

	// Duty registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_a_q <= vpo_pkg::DUTY_RESET;
			duty_b_q <= vpo_pkg::DUTY_RESET;
		end else if (cfg_we) begin
			if (cfg_index == vpo_pkg::REG_DUTY_A)
				duty_a_q <= cfg_data;
			if (cfg_index == vpo_pkg::REG_DUTY_B)
				duty_b_q <= cfg_data;
		end
	end

	vpo_front #(
		.VOICE_COUNT (VOICE_COUNT),
		.MAX_CATCHUP (MAX_CATCHUP)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop)
	);

	vpo_back #(
		.VOICE_COUNT (VOICE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop),
		.duty_a    (duty_a_q),
		.duty_b    (duty_b_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// The back end never takes a command from an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cmd_valid)
		else $error("queue popped while empty");

	// Only channels 0..2 exist on a chip
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.channel != 2'd3)
		else $error("channel out of range");

	// Start and stop always write level zero as a single final beat; this checks the last flag after a stop
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.op == vpo_pkg::OP_STOP) |=> (out_valid && out_data.last))
		else $error("stop without final beat");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int NVOICE = 6;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	vpo_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	vpo_pkg::out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [3:0] cfg_data = '0;

	// Predictor state, one entry per voice
	logic [15:0] pr_phase [NVOICE];
	logic [16:0] pr_step [NVOICE];
	logic pr_on [NVOICE];
	logic [3:0] pr_peak [NVOICE];
	logic [3:0] pr_duty [NVOICE];
	logic [1:0] pr_wave [NVOICE];
	logic [3:0] pr_written [NVOICE];
	logic [15:0] pr_lfo_phase [NVOICE];
	logic [15:0] pr_lfo_step [NVOICE];
	logic [3:0] pr_depth [NVOICE];
	logic pr_turn;
	logic [3:0] duty_a, duty_b;

	vpo_pkg::out_beat_t pending_writes [$];
	int errors = 0;
	int cycles = 0;
	logic out_idle_en = 1'b1;
	logic in_idle_en = 1'b1;

	volume_pwm_oscillator_bank i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL volume_pwm_oscillator_bank");
			$finish;
		end
	end

	function automatic logic [3:0] wave_out(int v, int duty);
		int p, pk, second;
		p = pr_phase[v];
		pk = pr_peak[v];
		case (pr_wave[v])
			vpo_pkg::WAVE_SAW: return 4'((pk * (65535 - p)) >> 16);
			vpo_pkg::WAVE_TRI: begin
				if (p < 32768) return 4'((pk * p) >> 15);
				return 4'((pk * (65535 - p)) >> 15);
			end
			vpo_pkg::WAVE_DPULSE: begin
				second = (duty + 1) * 4096;
				if (p < 4096 || (p >= second && p < second + 4096)) return 4'(pk);
				return 4'd0;
			end
			default: return (p < duty * 4096) ? 4'(pk) : 4'd0;
		endcase
	endfunction

	task automatic predict_writes(input vpo_pkg::in_beat_t b);
		int s, base, v, duty, p, m, st;
		logic [3:0] lvl;
		vpo_pkg::out_beat_t w;
		int n;
		n = 0;
		if (b.kind == vpo_pkg::KIND_TICK) begin
			s = b.steps;
			if (s < 1) s = 1;
			if (s > 10) s = 10;
			base = pr_turn * vpo_pkg::PER_CHIP;
			for (int c = 0; c < vpo_pkg::PER_CHIP; c++) begin
				v = base + c;
				if (pr_on[v] && pr_step[v] != 0)
					pr_phase[v] = 16'(pr_phase[v] + pr_step[v] * s);
			end
			for (int c = 0; c < vpo_pkg::PER_CHIP; c++) begin
				v = base + c;
				if (!pr_on[v] || pr_step[v] == 0) continue;
				duty = pr_duty[v];
				if (pr_lfo_step[v] != 0) begin
					pr_lfo_phase[v] = 16'(pr_lfo_phase[v] + pr_lfo_step[v] * s);
					p = pr_lfo_phase[v];
					if (p < 32768) m = pr_depth[v] * p / 32768;
					else m = pr_depth[v] * (65535 - p) / 32768;
					duty = duty + m;
					if (duty > 15) duty = 15;
				end
				lvl = wave_out(v, duty);
				if (lvl != pr_written[v]) begin
					pr_written[v] = lvl;
					w.chip = pr_turn;
					w.channel = 2'(c);
					w.level = lvl;
					w.last = 1'b0;
					pending_writes.push_back(w);
					n++;
				end
			end
			pr_turn = ~pr_turn;
			if (n > 0) pending_writes[$].last = 1'b1;
			return;
		end
		if (b.voice >= NVOICE) return;
		v = b.voice;
		case (b.kind)
			vpo_pkg::KIND_START: begin
				pr_peak[v] = '0;
				pr_phase[v] = vpo_pkg::PHASE_START;
				pr_on[v] = 1'b1;
				pr_duty[v] = (v < vpo_pkg::PER_CHIP) ? duty_a : duty_b;
				if (b.period == 0) pr_step[v] = '0;
				else begin
					st = 327680 / int'(b.period);
					if (st > 65536) st = 65536;
					if (st == 0) st = 1;
					pr_step[v] = 17'(st);
				end
			end
			vpo_pkg::KIND_STOP: begin
				pr_on[v] = 1'b0;
				pr_peak[v] = '0;
				pr_phase[v] = '0;
				pr_step[v] = '0;
			end
			default: begin
				pr_peak[v] = b.volume;
				pr_wave[v] = b.waveform;
				pr_depth[v] = b.pwm_depth;
				pr_lfo_step[v] = b.pwm_rate;
				return;
			end
		endcase
		pr_written[v] = '0;
		w.chip = (v >= vpo_pkg::PER_CHIP);
		w.channel = 2'(v % vpo_pkg::PER_CHIP);
		w.level = '0;
		w.last = 1'b1;
		pending_writes.push_back(w);
	endtask

	// Sends one beat, predicting its writes on acceptance; valid stays up
	// between back-to-back beats and drops only for idle gaps and drains
	task automatic send_beat(input vpo_pkg::in_beat_t b);
		int gap;
		if (in_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		predict_writes(b);
	endtask

	// Result side: random stalls and field checks
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_writes.size() == 0) begin
				$error("unexpected write chip=%0d channel=%0d level=%0d",
					out_data.chip, out_data.channel, out_data.level);
				errors++;
			end else begin
				vpo_pkg::out_beat_t e;
				e = pending_writes.pop_front();
				if (out_data.chip !== e.chip) begin
					$error("chip expected %0d actual %0d", e.chip, out_data.chip);
					errors++;
				end
				if (out_data.channel !== e.channel) begin
					$error("channel expected %0d actual %0d", e.channel, out_data.channel);
					errors++;
				end
				if (out_data.level !== e.level) begin
					$error("level expected %0d actual %0d", e.level, out_data.level);
					errors++;
				end
				if (out_data.last !== e.last) begin
					$error("last expected %0d actual %0d", e.last, out_data.last);
					errors++;
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (out_idle_en && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 11);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Drives one register write for a cycle; the caller drops the enable
	task automatic write_duty(input logic idx, input logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == vpo_pkg::REG_DUTY_A) duty_a = val;
		else duty_b = val;
	endtask

	function automatic vpo_pkg::in_beat_t mk(logic [1:0] k, logic [2:0] v);
		vpo_pkg::in_beat_t b;
		b.kind = k;
		b.steps = 4'($urandom);
		b.voice = v;
		b.period = 16'($urandom);
		b.volume = 4'($urandom);
		b.waveform = 2'($urandom);
		b.pwm_depth = 4'($urandom);
		b.pwm_rate = 16'($urandom);
		return b;
	endfunction

	task automatic send_set(int v, int vol, int wave, int dep, int rate);
		vpo_pkg::in_beat_t b;
		b = mk(vpo_pkg::KIND_SET, 3'(v));
		b.volume = 4'(vol);
		b.waveform = 2'(wave);
		b.pwm_depth = 4'(dep);
		b.pwm_rate = 16'(rate);
		send_beat(b);
	endtask

	task automatic send_start(int v, int per);
		vpo_pkg::in_beat_t b;
		b = mk(vpo_pkg::KIND_START, 3'(v));
		b.period = 16'(per);
		send_beat(b);
	endtask

	task automatic send_tick(int s);
		vpo_pkg::in_beat_t b;
		b = mk(vpo_pkg::KIND_TICK, 3'd0);
		b.steps = 4'(s);
		send_beat(b);
	endtask

	// Directed: extremes of period, steps and every waveform
	task automatic test_directed();
		send_start(0, 0);
		send_start(1, 1);
		send_start(2, 65535);
		send_start(3, 5);
		send_start(4, 7);
		send_start(5, 100);
		send_set(0, 15, vpo_pkg::WAVE_SQUARE, 15, 65535);
		send_set(1, 15, vpo_pkg::WAVE_SAW, 0, 0);
		send_set(2, 15, vpo_pkg::WAVE_TRI, 0, 0);
		send_set(3, 9, vpo_pkg::WAVE_DPULSE, 15, 4096);
		send_set(4, 15, vpo_pkg::WAVE_SQUARE, 3, 1);
		send_set(5, 15, vpo_pkg::WAVE_TRI, 0, 0);
		send_set(7, 15, vpo_pkg::WAVE_SAW, 0, 0);
		send_start(6, 3);
		send_tick(0);
		send_tick(15);
		send_tick(10);
		send_tick(1);
		send_tick(3);
		send_tick(7);
		send_beat(mk(vpo_pkg::KIND_STOP, 3'd1));
		send_beat(mk(vpo_pkg::KIND_STOP, 3'd7));
		send_tick(2);
		send_tick(2);
	endtask

	// Register settings, written only while idle
	task automatic test_duty_registers();
		logic [3:0] vals [4] = '{4'd0, 4'd15, 4'd3, 4'd11};
		foreach (vals[i]) begin
			drain();
			write_duty(vpo_pkg::REG_DUTY_A, vals[i]);
			write_duty(vpo_pkg::REG_DUTY_B, vals[3 - i]);
			cfg_we <= 1'b0;
			for (int v = 0; v < NVOICE; v++) send_start(v, $urandom_range(1, 4000));
			for (int v = 0; v < NVOICE; v++)
				send_set(v, $urandom_range(0, 15), $urandom_range(0, 3),
					$urandom_range(0, 15), $urandom_range(0, 3) == 0 ? 0 : $urandom);
			repeat (12) send_tick($urandom_range(0, 15));
		end
	endtask

	// Random mix weighted toward running voices and ticks
	task automatic test_random(int count);
		vpo_pkg::in_beat_t b;
		int r;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) drain();
			if (i == count - 60) begin
				in_idle_en = 1'b0;
				out_idle_en = 1'b0;
			end
			r = $urandom_range(0, 99);
			if (r < 60) b = mk(vpo_pkg::KIND_TICK, 3'($urandom));
			else if (r < 72) begin
				b = mk(vpo_pkg::KIND_START, 3'($urandom_range(0, 7)));
				if ($urandom_range(0, 2) != 0) b.period = 16'($urandom_range(0, 2000));
			end else if (r < 78) b = mk(vpo_pkg::KIND_STOP, 3'($urandom));
			else b = mk(vpo_pkg::KIND_SET, 3'($urandom));
			send_beat(b);
		end
	endtask

	initial begin
		for (int v = 0; v < NVOICE; v++) begin
			pr_phase[v] = '0; pr_step[v] = '0; pr_on[v] = 1'b0; pr_peak[v] = '0;
			pr_duty[v] = vpo_pkg::DUTY_RESET; pr_wave[v] = '0; pr_written[v] = '0;
			pr_lfo_phase[v] = '0; pr_lfo_step[v] = '0; pr_depth[v] = '0;
		end
		pr_turn = 1'b0;
		duty_a = vpo_pkg::DUTY_RESET;
		duty_b = vpo_pkg::DUTY_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_duty_registers();
		test_random(300);
		drain();
		if (errors == 0) begin
			$display("PASS volume_pwm_oscillator_bank");
		end else begin
			$display("FAIL volume_pwm_oscillator_bank");
		end
		$finish;
	end

endmodule
